/* sv/oprg_pkg.sv */
// ----------------------------------------------------------------------------
// oprg_pkg
// Types and constants shared by the order packet risk gate modules.
// ----------------------------------------------------------------------------
package oprg_pkg;

    // item kinds
    localparam logic [1:0] KIND_EVAL      = 2'd0;
    localparam logic [1:0] KIND_WRITE_EN  = 2'd1;
    localparam logic [1:0] KIND_CLEAR_CNT = 2'd2;
    localparam logic [1:0] KIND_CLEAR_SEQ = 2'd3;

    // configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MODE_FLAGS = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_QTY_LO     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_QTY_HI     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PX_LO      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PX_HI      = 3'd4;

    // mode flag bit positions
    localparam int MODE_GATE_ON     = 0;
    localparam int MODE_GAP_DETECT  = 1;
    localparam int MODE_NEED_KEY    = 2;
    localparam int MODE_ENFORCE_EN  = 3;
    localparam int MODE_NEED_ORDER  = 4;
    localparam logic [4:0] MODE_RESET = 5'd1;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef enum logic [1:0] {
        DEC_ACCEPT = 2'd0,
        DEC_REJECT = 2'd1,
        DEC_DROP   = 2'd2,
        DEC_PASS   = 2'd3
    } decision_t;

    typedef enum logic [2:0] {
        WHY_NONE        = 3'd0,
        WHY_MALFORMED   = 3'd1,
        WHY_GAP         = 3'd2,
        WHY_CFG_MISS    = 3'd3,
        WHY_NOT_ENABLED = 3'd4,
        WHY_SOFTWARE    = 3'd5,
        WHY_RISK        = 3'd6
    } why_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] seq_number;
        logic [63:0] rx_time;
        logic [15:0] declared_length;
        logic [15:0] actual_length;
        logic        has_key;
        logic [15:0] locate_index;
        logic        has_order;
        logic [31:0] quantity;
        logic [31:0] price;
        logic        enable_value;
    } in_item_t;

    typedef struct packed {
        decision_t   decision;
        why_t        why;
        logic [63:0] seq_echo;
        logic [63:0] rx_echo;
        logic [63:0] decided_time;
        logic [63:0] total_packets;
        logic [63:0] total_accepted;
        logic [63:0] total_rejected;
        logic [63:0] total_dropped;
        logic [63:0] total_passed;
        logic [63:0] total_malformed;
    } out_item_t;

    // one queued operation for the back part
    typedef struct packed {
        logic        clear_cnt;
        decision_t   decision;
        why_t        why;
        logic [63:0] seq_echo;
        logic [63:0] rx_echo;
    } op_t;

    // configuration held by the front part
    typedef struct packed {
        logic [4:0]  mode_flags;
        logic [31:0] qty_lo;
        logic [31:0] qty_hi;
        logic [31:0] px_lo;
        logic [31:0] px_hi;
    } cfg_t;

endpackage

/* sv/oprg_queue.sv */
// ----------------------------------------------------------------------------
// oprg_queue
// Short first-in first-out queue of classified operations.
// ----------------------------------------------------------------------------
module oprg_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  oprg_pkg::op_t  push_op,
    output logic           pop_valid,
    input  logic           pop_ready,
    output oprg_pkg::op_t  pop_op
);

    oprg_pkg::op_t                 slot_reg [oprg_pkg::QUEUE_DEPTH];
    logic [oprg_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [oprg_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [oprg_pkg::QPTR_W:0]     count_reg;
    logic [oprg_pkg::QPTR_W:0]     count_next;
    logic                          push_fire;
    logic                          pop_fire;

    assign push_ready = (count_reg != (oprg_pkg::QPTR_W+1)'(oprg_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_op     = slot_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push_fire && !pop_fire)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_fire && !push_fire)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push_fire)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop_fire)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

/* sv/oprg_front.sv */
// ----------------------------------------------------------------------------
// oprg_front
// Takes items and configuration, keeps the enable bits and sequence
// tracking, and turns each evaluate or counter clear item into an operation.
// ----------------------------------------------------------------------------
module oprg_front #(
    parameter int LOCATE_ENTRIES = 8192
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  oprg_pkg::in_item_t                  in_item,
    input  logic                                cfg_valid,
    input  logic [oprg_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [31:0]                         cfg_data,
    output logic                                push_valid,
    input  logic                                push_ready,
    output oprg_pkg::op_t                       push_op
);

    localparam int AW = (LOCATE_ENTRIES > 1) ? $clog2(LOCATE_ENTRIES) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(LOCATE_ENTRIES - 1);

    oprg_pkg::cfg_t      cfg_reg;
    logic [63:0]         expected_seq_reg;
    logic [63:0]         expected_seq_next;

    // enable bit memory and clearing pass
    logic                en_mem [0:LOCATE_ENTRIES-1];
    logic                clearing_reg;
    logic [AW-1:0]       clear_addr_reg;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic                mem_wdata;
    logic                en_rd_reg;

    // stage holding the accepted item
    logic                a_valid_reg;
    oprg_pkg::in_item_t  a_item_reg;
    logic                a_in_range_reg;

    logic                in_fire;
    logic                in_range;
    logic                a_needs_push;
    logic                a_fire;
    logic                len_bad;
    logic                gap_apply;
    logic                gap_hit;
    logic                qty_ok;
    logic                px_ok;
    logic                en_ok;
    oprg_pkg::decision_t dec;
    oprg_pkg::why_t      why;

    assign in_range     = ({1'b0, in_item.locate_index} < 17'(LOCATE_ENTRIES));
    assign a_needs_push = (a_item_reg.kind == oprg_pkg::KIND_EVAL)
                       || (a_item_reg.kind == oprg_pkg::KIND_CLEAR_CNT);
    assign a_fire       = a_valid_reg && (!a_needs_push || push_ready);
    assign in_ready     = !clearing_reg && (!a_valid_reg || a_fire);
    assign in_fire      = in_valid && in_ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode_flags <= oprg_pkg::MODE_RESET;
            cfg_reg.qty_lo     <= '0;
            cfg_reg.qty_hi     <= '1;
            cfg_reg.px_lo      <= '0;
            cfg_reg.px_hi      <= '1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                oprg_pkg::CFG_MODE_FLAGS: cfg_reg.mode_flags <= cfg_data[4:0];
                oprg_pkg::CFG_QTY_LO:     cfg_reg.qty_lo     <= cfg_data;
                oprg_pkg::CFG_QTY_HI:     cfg_reg.qty_hi     <= cfg_data;
                oprg_pkg::CFG_PX_LO:      cfg_reg.px_lo      <= cfg_data;
                oprg_pkg::CFG_PX_HI:      cfg_reg.px_hi      <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // clearing pass sets every enable bit after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg   <= 1'b1;
            clear_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clear_addr_reg <= clear_addr_reg + 1'b1;
            if (clear_addr_reg == LAST_ADDR)
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // single write port shared by the clearing pass and bit writes
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = in_item.locate_index[AW-1:0];
        mem_wdata = in_item.enable_value;
        if (clearing_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clear_addr_reg;
            mem_wdata = 1'b1;
        end
        else if (in_fire && (in_item.kind == oprg_pkg::KIND_WRITE_EN) && in_range)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            en_mem[mem_waddr] <= mem_wdata;
        end
        if (in_fire)
        begin
            en_rd_reg <= en_mem[in_item.locate_index[AW-1:0]];
        end
    end

    // item stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (a_fire)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_item_reg     <= in_item;
            a_in_range_reg <= in_range;
        end
    end

    // check chain, first failing check decides
    always_comb
    begin
        len_bad   = (a_item_reg.actual_length == '0)
                 || (a_item_reg.declared_length != a_item_reg.actual_length);
        gap_apply = cfg_reg.mode_flags[oprg_pkg::MODE_GAP_DETECT]
                 && (a_item_reg.seq_number != '0);
        gap_hit   = (expected_seq_reg != '0) && (a_item_reg.seq_number != expected_seq_reg);
        qty_ok    = (a_item_reg.quantity >= cfg_reg.qty_lo)
                 && (a_item_reg.quantity <= cfg_reg.qty_hi);
        px_ok     = (a_item_reg.price >= cfg_reg.px_lo)
                 && (a_item_reg.price <= cfg_reg.px_hi);
        en_ok     = a_in_range_reg && en_rd_reg;
        dec       = oprg_pkg::DEC_ACCEPT;
        why       = oprg_pkg::WHY_NONE;
        expected_seq_next = expected_seq_reg;

        if (!cfg_reg.mode_flags[oprg_pkg::MODE_GATE_ON])
        begin
            dec = oprg_pkg::DEC_PASS;
            why = oprg_pkg::WHY_SOFTWARE;
        end
        else if (len_bad)
        begin
            dec = oprg_pkg::DEC_DROP;
            why = oprg_pkg::WHY_MALFORMED;
        end
        else
        begin
            if (gap_apply)
            begin
                expected_seq_next = a_item_reg.seq_number + 64'd1;
            end
            if (gap_apply && gap_hit)
            begin
                dec = oprg_pkg::DEC_REJECT;
                why = oprg_pkg::WHY_GAP;
            end
            else if (cfg_reg.mode_flags[oprg_pkg::MODE_NEED_KEY] && !a_item_reg.has_key)
            begin
                dec = oprg_pkg::DEC_PASS;
                why = oprg_pkg::WHY_CFG_MISS;
            end
            else if (cfg_reg.mode_flags[oprg_pkg::MODE_ENFORCE_EN] && !en_ok)
            begin
                dec = oprg_pkg::DEC_REJECT;
                why = oprg_pkg::WHY_NOT_ENABLED;
            end
            else if (cfg_reg.mode_flags[oprg_pkg::MODE_NEED_ORDER] && !a_item_reg.has_order)
            begin
                dec = oprg_pkg::DEC_PASS;
                why = oprg_pkg::WHY_SOFTWARE;
            end
            else if (a_item_reg.has_order && !(qty_ok && px_ok))
            begin
                dec = oprg_pkg::DEC_REJECT;
                why = oprg_pkg::WHY_RISK;
            end
        end

        if (a_item_reg.kind == oprg_pkg::KIND_CLEAR_SEQ)
        begin
            expected_seq_next = '0;
        end
        else if (a_item_reg.kind != oprg_pkg::KIND_EVAL)
        begin
            expected_seq_next = expected_seq_reg;
        end
    end

    // sequence tracking advances with the item stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_seq_reg <= '0;
        end
        else if (a_fire)
        begin
            expected_seq_reg <= expected_seq_next;
        end
    end

    // operation towards the back part
    assign push_valid         = a_valid_reg && a_needs_push;
    assign push_op.clear_cnt  = (a_item_reg.kind == oprg_pkg::KIND_CLEAR_CNT);
    assign push_op.decision   = dec;
    assign push_op.why        = why;
    assign push_op.seq_echo   = a_item_reg.seq_number;
    assign push_op.rx_echo    = a_item_reg.rx_time;

endmodule

/* sv/oprg_back.sv */
// ----------------------------------------------------------------------------
// oprg_back
// Carries out queued operations: keeps the decision counters and holds
// the result transaction in an output register.
// ----------------------------------------------------------------------------
module oprg_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  oprg_pkg::op_t       pop_op,
    output logic                out_valid,
    input  logic                out_ready,
    output oprg_pkg::out_item_t out_item
);

    logic [63:0]         cnt_packets_reg;
    logic [63:0]         cnt_accepted_reg;
    logic [63:0]         cnt_rejected_reg;
    logic [63:0]         cnt_dropped_reg;
    logic [63:0]         cnt_passed_reg;
    logic [63:0]         cnt_malformed_reg;
    logic [63:0]         cnt_packets_next;
    logic [63:0]         cnt_accepted_next;
    logic [63:0]         cnt_rejected_next;
    logic [63:0]         cnt_dropped_next;
    logic [63:0]         cnt_passed_next;
    logic [63:0]         cnt_malformed_next;

    logic                out_valid_reg;
    oprg_pkg::out_item_t out_reg;
    logic                pop_fire;
    logic                eval_fire;

    assign pop_ready = pop_op.clear_cnt || !out_valid_reg || out_ready;
    assign pop_fire  = pop_valid && pop_ready;
    assign eval_fire = pop_fire && !pop_op.clear_cnt;

    // counter values after this transaction
    always_comb
    begin
        cnt_packets_next   = cnt_packets_reg + 64'd1;
        cnt_accepted_next  = cnt_accepted_reg;
        cnt_rejected_next  = cnt_rejected_reg;
        cnt_dropped_next   = cnt_dropped_reg;
        cnt_passed_next    = cnt_passed_reg;
        cnt_malformed_next = cnt_malformed_reg;
        case (pop_op.decision)
            oprg_pkg::DEC_ACCEPT: cnt_accepted_next = cnt_accepted_reg + 64'd1;
            oprg_pkg::DEC_REJECT: cnt_rejected_next = cnt_rejected_reg + 64'd1;
            oprg_pkg::DEC_DROP:   cnt_dropped_next  = cnt_dropped_reg + 64'd1;
            oprg_pkg::DEC_PASS:   cnt_passed_next   = cnt_passed_reg + 64'd1;
            default:              ;
        endcase
        if (pop_op.why == oprg_pkg::WHY_MALFORMED)
        begin
            cnt_malformed_next = cnt_malformed_reg + 64'd1;
        end
    end

    // decision counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_packets_reg   <= '0;
            cnt_accepted_reg  <= '0;
            cnt_rejected_reg  <= '0;
            cnt_dropped_reg   <= '0;
            cnt_passed_reg    <= '0;
            cnt_malformed_reg <= '0;
        end
        else if (pop_fire && pop_op.clear_cnt)
        begin
            cnt_packets_reg   <= '0;
            cnt_accepted_reg  <= '0;
            cnt_rejected_reg  <= '0;
            cnt_dropped_reg   <= '0;
            cnt_passed_reg    <= '0;
            cnt_malformed_reg <= '0;
        end
        else if (eval_fire)
        begin
            cnt_packets_reg   <= cnt_packets_next;
            cnt_accepted_reg  <= cnt_accepted_next;
            cnt_rejected_reg  <= cnt_rejected_next;
            cnt_dropped_reg   <= cnt_dropped_next;
            cnt_passed_reg    <= cnt_passed_next;
            cnt_malformed_reg <= cnt_malformed_next;
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (eval_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (eval_fire)
        begin
            out_reg.decision        <= pop_op.decision;
            out_reg.why             <= pop_op.why;
            out_reg.seq_echo        <= pop_op.seq_echo;
            out_reg.rx_echo         <= pop_op.rx_echo;
            out_reg.decided_time    <= (pop_op.rx_echo == '0) ? '0 : pop_op.rx_echo + 64'd1;
            out_reg.total_packets   <= cnt_packets_next;
            out_reg.total_accepted  <= cnt_accepted_next;
            out_reg.total_rejected  <= cnt_rejected_next;
            out_reg.total_dropped   <= cnt_dropped_next;
            out_reg.total_passed    <= cnt_passed_next;
            out_reg.total_malformed <= cnt_malformed_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

/* sv/order_packet_risk_gate.sv */
// ----------------------------------------------------------------------------
// order_packet_risk_gate
// Pre-trade risk check gate: classifies packet metadata and keeps counters.
// ----------------------------------------------------------------------------
// usage
//   in_valid/in_ready/in_item: one transaction per item; kind selects evaluate,
//     enable bit write, counter clear or sequence tracking clear
//   out_valid/out_ready/out_item: one result transaction per evaluate item,
//     in input order; other kinds give none
//   cfg_valid/cfg_ready/cfg_index/cfg_data: register writes, always ready,
//     to be issued only while the block holds no work
//   path: an item passes the item stage, the queue and the output register
//   throughput: one item per cycle while nothing stalls; the enable bit memory is read at accept
//     and written at accept, one port each, and the counters update at most once
//     per cycle in the back part
//   reset: after rst_n rises, in_ready stays low while the clearing pass sets
//     every enable bit; configuration writes are taken meanwhile
//   receiver stall: the output register holds, the four-entry queue fills,
//     then in_ready drops; nothing is lost or repeated
// ----------------------------------------------------------------------------
module order_packet_risk_gate #(
    parameter int LOCATE_ENTRIES = 8192
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  oprg_pkg::in_item_t               in_item,
    output logic                             out_valid,
    input  logic                             out_ready,
    output oprg_pkg::out_item_t              out_item,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [oprg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                      cfg_data
);

    logic          push_valid;
    logic          push_ready;
    oprg_pkg::op_t push_op;
    logic          pop_valid;
    logic          pop_ready;
    oprg_pkg::op_t pop_op;

    assign cfg_ready = 1'b1;

    // classification
    oprg_front #(
        .LOCATE_ENTRIES (LOCATE_ENTRIES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op)
    );

    // decoupling queue
    oprg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_op     (pop_op)
    );

    // counters and result register
    oprg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_op    (pop_op),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule
